### sv/qfas_pkg.sv
// Package for the quad-precision add/sub core: widths, operand class types and
// the front-to-back queue record. No dependencies.
`timescale 1ns / 1ps
package qfas_pkg;
	localparam int SIG_W = 112;
	localparam int EXT_W = 120;
	localparam int EXP_W = 15;
	localparam int DATA_W = 256;
	localparam int QDEPTH = 2;
	localparam logic [EXP_W-1:0] EXP_ONES = 15'h7fff;

	typedef enum logic [1:0] {
		K_NUM,
		K_NAN,
		K_INF
	} kind_t;

	typedef struct packed {
		logic [EXT_W-1:0] sig;
		logic [EXP_W-1:0] exp;
		logic             sign;
		kind_t            kind;
	} opnd_t;

	typedef struct packed {
		opnd_t a;
		opnd_t b;
	} pair_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_ALIGN,
		ST_NORM,
		ST_DONE
	} state_t;
endpackage

### sv/qfas_front.sv
// Front end: unpacks and classifies both operands into a two-entry queue.
// Depends on qfas_pkg.
`timescale 1ns / 1ps
module qfas_front (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [qfas_pkg::DATA_W:0] in_data,
	output logic                  q_valid,
	input  logic                  q_ready,
	output qfas_pkg::pair_t       q_data
);
	import qfas_pkg::*;

	pair_t     mem_q [QDEPTH];
	logic      wp_q, rp_q;
	logic [1:0] cnt_q;

	function automatic opnd_t unpk(input logic [127:0] w, input logic flip);
		opnd_t o;
		logic  z;
		z = (w[SIG_W-1:0] == '0);
		o.sig = {8'd0, w[SIG_W-1:0]};
		o.exp = w[126:112];
		o.sign = w[127] ^ flip;
		o.kind = K_NUM;
		if (o.exp == EXP_ONES) begin
			o.kind = z ? K_INF : K_NAN;
		end else if (o.exp != '0) begin
			o.sig[SIG_W] = 1'b1;
		end else begin
			o.exp = 15'd1;
		end
		return o;
	endfunction

	assign in_ready = (cnt_q != 2'(QDEPTH));
	assign q_valid = (cnt_q != 2'd0);
	assign q_data = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			mem_q[wp_q] <= '{a: unpk(in_data[128:1], 1'b0),
				b: unpk(in_data[256:129], in_data[0])};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0;
			rp_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (in_valid && in_ready) wp_q <= ~wp_q;
			if (q_valid && q_ready) rp_q <= ~rp_q;
			cnt_q <= cnt_q + 2'(in_valid && in_ready) - 2'(q_valid && q_ready);
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n) cnt_q <= 2'(QDEPTH))
		else $error("queue count overflow");
	assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q == 2'(QDEPTH)) |-> !in_ready) else $error("ready while full");
	assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q == 2'd0) |-> !q_valid) else $error("valid while empty");
endmodule

### sv/qfas_back.sv
// Back end: aligns, adds and renormalizes one operand pair at a time.
// Depends on qfas_pkg.
`timescale 1ns / 1ps
module qfas_back (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            q_valid,
	output logic            q_ready,
	input  qfas_pkg::pair_t q_data,
	output logic            out_valid,
	input  logic            out_ready,
	output logic [127:0]    out_data
);
	import qfas_pkg::*;

	state_t           st_q, st_d;
	opnd_t            a_q, b_q;
	logic [7:0]       d_q;
	logic [EXT_W-1:0] s_q;
	logic [16:0]      e_q;
	logic             neg_q;
	logic [127:0]     res_q;
	logic             take;
	logic [EXT_W-1:0] av, bv, sum, mag;
	logic [14:0]      dd;
	logic             nrm_r, nrm_l, nrm_end;

	assign take = q_valid && q_ready;
	assign dd = (q_data.a.exp < q_data.b.exp) ? q_data.b.exp - q_data.a.exp
		: q_data.a.exp - q_data.b.exp;
	assign av = a_q.sign ? -a_q.sig : a_q.sig;
	assign bv = b_q.sign ? -b_q.sig : b_q.sig;
	assign sum = av + bv;
	assign mag = sum[EXT_W-1] ? -sum : sum;
	assign nrm_r = (s_q[EXT_W-1:SIG_W] > 8'd1);
	assign nrm_l = (s_q[EXT_W-1:SIG_W] == 8'd0) && (e_q > 17'd1) && (s_q != '0);
	assign nrm_end = !nrm_r && !nrm_l;

	always_comb begin
		st_d = st_q;
		case (st_q)
			ST_IDLE: if (take) st_d = ST_ALIGN;
			ST_ALIGN: if (d_q == 8'd0) st_d = ST_NORM;
			ST_NORM: if (nrm_end) st_d = ST_DONE;
			ST_DONE: if (out_ready) st_d = ST_IDLE;
			default: st_d = ST_IDLE;
		endcase
	end

	always_comb begin
		q_ready = (st_q == ST_IDLE);
		out_valid = (st_q == ST_DONE);
		out_data = res_q;
	end

	always_ff @(posedge clk) begin
		case (st_q)
			ST_IDLE: if (take) begin
				if (q_data.a.exp < q_data.b.exp) begin
					a_q <= q_data.b;
					b_q <= q_data.a;
				end else begin
					a_q <= q_data.a;
					b_q <= q_data.b;
				end
				d_q <= (dd > 15'(EXT_W)) ? 8'(EXT_W) : dd[7:0];
			end
			ST_ALIGN: if (d_q != 8'd0) begin
				b_q.sig <= b_q.sig >> 1;
				d_q <= d_q - 8'd1;
			end else begin
				s_q <= mag;
				neg_q <= sum[EXT_W-1];
				e_q <= {2'd0, a_q.exp};
			end
			ST_NORM: begin
				if (nrm_r) begin
					s_q <= s_q >> 1;
					e_q <= e_q + 17'd1;
				end else if (nrm_l) begin
					s_q <= s_q << 1;
					e_q <= e_q - 17'd1;
				end
			end
			default: ;
		endcase
		if (st_q == ST_NORM && nrm_end) begin
			if (a_q.kind == K_NAN)
				res_q <= {a_q.sign, EXP_ONES, a_q.sig[SIG_W-1:1], 1'b1};
			else if (b_q.kind == K_NAN)
				res_q <= {b_q.sign, EXP_ONES, b_q.sig[SIG_W-1:1], 1'b1};
			else if (a_q.kind == K_INF && b_q.kind == K_INF)
				res_q <= (a_q.sign != b_q.sign) ?
					{a_q.sign, EXP_ONES, 111'd0, 1'b1} : {a_q.sign, EXP_ONES, 112'd0};
			else if (a_q.kind == K_INF)
				res_q <= {a_q.sign, EXP_ONES, 112'd0};
			else if (b_q.kind == K_INF)
				res_q <= {b_q.sign, EXP_ONES, 112'd0};
			else if (s_q == '0)
				res_q <= '0;
			else if (e_q >= 17'(EXP_ONES))
				res_q <= {neg_q, EXP_ONES, 112'd0};
			else
				res_q <= {neg_q, (s_q[SIG_W] ? e_q[14:0] : 15'd0), s_q[SIG_W-1:0]};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) st_q <= ST_IDLE;
		else st_q <= st_d;
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		take |=> (st_q == ST_ALIGN)) else $error("take did not start align");
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> out_valid && $stable(out_data))
		else $error("result dropped");
	assert property (@(posedge clk) disable iff (!arst_n)
		!(q_ready && out_valid)) else $error("overlap");
endmodule

### sv/quad_float_add_sub_core.sv
// Top level of the quad-precision add/sub core; joins qfas_front and qfas_back.
// Flow: the back end's bit-serial shifter takes a new pair only after its last result is accepted.
// Reset: arst_n clears the queue and state machine asynchronously.
// Depends on qfas_pkg, qfas_front, qfas_back.
`timescale 1ns / 1ps
module quad_float_add_sub_core (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	input  logic [263:0] s_axis_tdata, // func, a_low, a_high, b_low, b_high, zero pad
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	output logic [127:0] m_axis_tdata  // sum_low, sum_high
);
	import qfas_pkg::*;

	logic  qv, qr;
	pair_t qd;

	qfas_front u_front (
		.clk(clk), .arst_n(arst_n),
		.in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
		.in_data(s_axis_tdata[DATA_W:0]),
		.q_valid(qv), .q_ready(qr), .q_data(qd)
	);

	qfas_back u_back (
		.clk(clk), .arst_n(arst_n),
		.q_valid(qv), .q_ready(qr), .q_data(qd),
		.out_valid(m_axis_tvalid), .out_ready(m_axis_tready),
		.out_data(m_axis_tdata)
	);
endmodule
